/* hw/rtl/tagged_integer_alu_defines.svh */
// Assertion macros shared by the tagged integer ALU sources.
`ifndef TAGGED_INTEGER_ALU_DEFINES_SVH
`define TAGGED_INTEGER_ALU_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define TIA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define TIA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define TIA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TIA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/tia_pkg.sv */
// Types, command codes and helpers for the tagged integer ALU.
package tia_pkg;

   // Datum layout.
   localparam int MAG_BITS = 45;
   localparam int TAG_SHIFT = 46;
   localparam logic [63:0] SIGN_FLIP = 64'h0000200000000000;
   localparam logic [63:0] LOW46_MASK = 64'h00003fffffffffff;

   // Divider slicing: quotient bits retired per pipeline stage.
   localparam int DIV_BITS_PER_STAGE = 3;
   localparam int DIV_STAGES = MAG_BITS / DIV_BITS_PER_STAGE;

   // Multiplier split point for the partial products.
   localparam int MUL_SPLIT = 23;

   // Command codes.
   localparam logic [4:0] CMD_ADD    = 5'd0;
   localparam logic [4:0] CMD_SUB    = 5'd1;
   localparam logic [4:0] CMD_MUL    = 5'd2;
   localparam logic [4:0] CMD_DIV    = 5'd3;
   localparam logic [4:0] CMD_DIVREM = 5'd4;
   localparam logic [4:0] CMD_BSUBA  = 5'd5;
   localparam logic [4:0] CMD_INC    = 5'd6;
   localparam logic [4:0] CMD_DEC    = 5'd7;
   localparam logic [4:0] CMD_LT     = 5'd8;
   localparam logic [4:0] CMD_GT     = 5'd9;
   localparam logic [4:0] CMD_LE     = 5'd10;
   localparam logic [4:0] CMD_GE     = 5'd11;
   localparam logic [4:0] CMD_EQ     = 5'd12;
   localparam logic [4:0] CMD_NE     = 5'd13;
   localparam logic [4:0] CMD_ISNUM  = 5'd14;
   localparam logic [4:0] CMD_NOTNUM = 5'd15;
   localparam logic [4:0] CMD_NOP    = 5'd16;
   localparam logic [4:0] CMD_PASS   = 5'd17;

   typedef struct packed {
      logic [4:0]  command;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } tia_req_type;

   typedef struct packed {
      logic        fires;
      logic [63:0] result_a;
      logic [63:0] result_b;
      logic        divide_by_zero;
   } tia_rsp_type;

   // One word in flight through the divider pipeline.
   typedef struct packed {
      logic        valid;
      logic [4:0]  cmd;
      logic        fires;
      logic        dz;
      logic [63:0] val;
      logic        mul_pend;
      logic        neg_pend;
      logic        enc_pend;
      logic        sign_q;
      logic        sign_r;
      logic [MAG_BITS-1:0] dvsr;
      logic [MAG_BITS-1:0] rem;
      logic [MAG_BITS-1:0] dq;
   } tia_pipe_type;

   // Re-encode a two's complement value as a sign-magnitude datum.
   function automatic logic [63:0] tia_encode(input logic [63:0] v);
      logic [63:0] r;
      if (v[63]) begin
         r = ((64'd0 - v) + SIGN_FLIP) & LOW46_MASK;
      end else begin
         r = v & LOW46_MASK;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/tia_div_step.sv */
// One slice of the restoring divider: retires DIV_BITS_PER_STAGE quotient bits.
module tia_div_step (
   input  logic [tia_pkg::MAG_BITS-1:0] rem_i,
   input  logic [tia_pkg::MAG_BITS-1:0] dq_i,
   input  logic [tia_pkg::MAG_BITS-1:0] dvsr_i,
   output logic [tia_pkg::MAG_BITS-1:0] rem_o,
   output logic [tia_pkg::MAG_BITS-1:0] dq_o
);

   // Shift in the next dividend bit, subtract the divisor when it fits.
   always_comb begin
      logic [tia_pkg::MAG_BITS:0]   trial;
      logic [tia_pkg::MAG_BITS-1:0] r;
      logic [tia_pkg::MAG_BITS-1:0] q;
      r = rem_i;
      q = dq_i;
      trial = '0;
      for (int i = 0; i < tia_pkg::DIV_BITS_PER_STAGE; i++) begin
         trial = {r, q[tia_pkg::MAG_BITS-1]};
         q = {q[tia_pkg::MAG_BITS-2:0], 1'b0};
         if (trial >= {1'b0, dvsr_i}) begin
            trial = trial - {1'b0, dvsr_i};
            q[0] = 1'b1;
         end
         r = trial[tia_pkg::MAG_BITS-1:0];
      end
      rem_o = r;
      dq_o = q;
   end

endmodule

/* hw/rtl/tagged_integer_alu.sv */
// Top level of the tagged integer ALU pipeline.
// Every word gives exactly one result word, in order, after passing the input
// register, operation stage, 15 divider stages of 3 quotient bits each and the
// output register. One word may enter in every cycle while req_stall is low; the
// throughput is then one word per cycle. The whole pipeline advances together:
// when a result sits in the output register and is stalled, req_stall rises and
// nothing moves. Multiply uses four partial products of 23/22-bit magnitude halves,
// summed, negated and encoded over the first divider stages, beside the division.
`include "tagged_integer_alu_defines.svh"

module tagged_integer_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tia_pkg::tia_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tia_pkg::tia_rsp_type rsp_data
);

   localparam int MB = tia_pkg::MAG_BITS;
   localparam int DS = tia_pkg::DIV_STAGES;
   localparam int MS = tia_pkg::MUL_SPLIT;
   localparam int HB = MB - MS;
   localparam int MUL_SUM_STAGE = 1;
   localparam int MUL_NEG_STAGE = 2;
   localparam int ENC_STAGE = 3;

   typedef struct packed {
      logic        valid;
      logic [4:0]  cmd;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] x;
      logic [63:0] y;
      logic [MB-1:0] ma;
      logic [MB-1:0] mb;
      logic        na;
      logic        nb;
      logic        numa;
      logic        numb;
   } in1_type;

   logic advance;
   in1_type in1_ff, in1_in;
   tia_pkg::tia_pipe_type pipe_ff [0:DS];
   tia_pkg::tia_pipe_type pipe_in [0:DS];
   logic [2*MS-1:0]  pp_ll_ff, pp_ll_in;
   logic [MS+HB-1:0] pp_hl_ff, pp_hl_in;
   logic [MS+HB-1:0] pp_lh_ff, pp_lh_in;
   logic [2*HB-1:0]  pp_hh_ff, pp_hh_in;
   logic [63:0] mul_sum;
   logic out_valid_ff;
   tia_pkg::tia_rsp_type out_data_ff, out_data_in;

   // The pipeline moves as one unless a result word is stalled at the output.
   assign advance = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;

   // Input stage: split and decode the two datums.
   always_comb begin
      in1_in.valid = req_valid;
      in1_in.cmd = req_data.command;
      in1_in.a = req_data.operand_a;
      in1_in.b = req_data.operand_b;
      in1_in.ma = req_data.operand_a[MB-1:0];
      in1_in.mb = req_data.operand_b[MB-1:0];
      in1_in.na = req_data.operand_a[MB];
      in1_in.nb = req_data.operand_b[MB];
      in1_in.numa = (req_data.operand_a[63:tia_pkg::TAG_SHIFT] == '0);
      in1_in.numb = (req_data.operand_b[63:tia_pkg::TAG_SHIFT] == '0);
      in1_in.x = req_data.operand_a[MB] ? 64'd0 - {{(64-MB){1'b0}}, req_data.operand_a[MB-1:0]}
                                        : {{(64-MB){1'b0}}, req_data.operand_a[MB-1:0]};
      in1_in.y = req_data.operand_b[MB] ? 64'd0 - {{(64-MB){1'b0}}, req_data.operand_b[MB-1:0]}
                                        : {{(64-MB){1'b0}}, req_data.operand_b[MB-1:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in1_ff.valid <= 1'b0;
      end else if (advance) begin
         in1_ff <= in1_in;
      end
   end

   // Operation stage: add, subtract, increment, decrement, compares, tag tests, partial products, divider setup.
   always_comb begin
      logic both;
      tia_pkg::tia_pipe_type h;
      both = in1_ff.numa && in1_ff.numb;
      h = '0;
      h.valid = in1_ff.valid;
      h.cmd = in1_ff.cmd;
      h.sign_q = in1_ff.na ^ in1_ff.nb;
      h.sign_r = in1_ff.na;
      h.dvsr = in1_ff.mb;
      h.rem = '0;
      h.dq = in1_ff.ma;
      unique case (in1_ff.cmd) inside
         tia_pkg::CMD_ADD: begin
            h.fires = both;
            h.val = both ? in1_ff.x + in1_ff.y : 64'd0;
            h.enc_pend = 1'b1;
         end
         tia_pkg::CMD_SUB: begin
            h.fires = both;
            h.val = both ? in1_ff.x - in1_ff.y : 64'd0;
            h.enc_pend = 1'b1;
         end
         tia_pkg::CMD_BSUBA: begin
            h.fires = both;
            h.val = both ? in1_ff.y - in1_ff.x : 64'd0;
            h.enc_pend = 1'b1;
         end
         tia_pkg::CMD_INC: begin
            h.fires = in1_ff.numa;
            h.val = in1_ff.numa ? in1_ff.x + 64'd1 : 64'd0;
            h.enc_pend = 1'b1;
         end
         tia_pkg::CMD_DEC: begin
            h.fires = in1_ff.numa;
            h.val = in1_ff.numa ? in1_ff.x - 64'd1 : 64'd0;
            h.enc_pend = 1'b1;
         end
         tia_pkg::CMD_MUL: begin
            h.fires = both;
            h.mul_pend = both;
            h.neg_pend = in1_ff.na ^ in1_ff.nb;
            h.enc_pend = 1'b1;
         end
         tia_pkg::CMD_DIV, tia_pkg::CMD_DIVREM: begin
            h.dz = both && (in1_ff.mb == '0);
            h.fires = both && (in1_ff.mb != '0);
         end
         tia_pkg::CMD_LT: h.fires = both && ($signed(in1_ff.x) < $signed(in1_ff.y));
         tia_pkg::CMD_GT: h.fires = both && ($signed(in1_ff.y) < $signed(in1_ff.x));
         tia_pkg::CMD_LE: h.fires = both && !($signed(in1_ff.y) < $signed(in1_ff.x));
         tia_pkg::CMD_GE: h.fires = both && !($signed(in1_ff.x) < $signed(in1_ff.y));
         tia_pkg::CMD_EQ: h.fires = (in1_ff.a == in1_ff.b);
         tia_pkg::CMD_NE: h.fires = (in1_ff.a != in1_ff.b);
         tia_pkg::CMD_ISNUM: h.fires = in1_ff.numa;
         tia_pkg::CMD_NOTNUM: h.fires = !in1_ff.numa;
         tia_pkg::CMD_NOP: h.fires = 1'b1;
         tia_pkg::CMD_PASS: begin
            h.fires = 1'b1;
            h.val = in1_ff.a;
         end
         default: h.fires = 1'b0;
      endcase
      pipe_in[0] = h;
   end

   // Four narrow partial products of the two magnitudes.
   assign pp_ll_in = in1_ff.ma[MS-1:0] * in1_ff.mb[MS-1:0];
   assign pp_hl_in = in1_ff.ma[MB-1:MS] * in1_ff.mb[MS-1:0];
   assign pp_lh_in = in1_ff.ma[MS-1:0] * in1_ff.mb[MB-1:MS];
   assign pp_hh_in = in1_ff.ma[MB-1:MS] * in1_ff.mb[MB-1:MS];

   always_ff @(posedge clock) begin
      if (advance) begin
         pp_ll_ff <= pp_ll_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_hh_ff <= pp_hh_in;
      end
   end

   // Low 64 bits of the magnitude product.
   assign mul_sum = {{(64-2*MS){1'b0}}, pp_ll_ff}
                  + ({{(64-MS-HB){1'b0}}, pp_hl_ff} << MS)
                  + ({{(64-MS-HB){1'b0}}, pp_lh_ff} << MS)
                  + ({{(64-2*HB){1'b0}}, pp_hh_ff} << (2*MS));

   // Divider stages; the early stages also finish multiply and encoding.
   for (genvar k = 1; k <= DS; k++) begin : g_div
      logic [MB-1:0] rem_nx;
      logic [MB-1:0] dq_nx;

      tia_div_step u_step (
         .rem_i  (pipe_ff[k-1].rem),
         .dq_i   (pipe_ff[k-1].dq),
         .dvsr_i (pipe_ff[k-1].dvsr),
         .rem_o  (rem_nx),
         .dq_o   (dq_nx)
      );

      always_comb begin
         pipe_in[k] = pipe_ff[k-1];
         pipe_in[k].rem = rem_nx;
         pipe_in[k].dq = dq_nx;
         if (k == MUL_SUM_STAGE) begin
            if (pipe_ff[k-1].mul_pend) begin
               pipe_in[k].val = mul_sum;
            end
         end
         if (k == MUL_NEG_STAGE) begin
            if (pipe_ff[k-1].neg_pend) begin
               pipe_in[k].val = 64'd0 - pipe_ff[k-1].val;
            end
         end
         if (k == ENC_STAGE) begin
            if (pipe_ff[k-1].enc_pend) begin
               pipe_in[k].val = tia_pkg::tia_encode(pipe_ff[k-1].val);
            end
         end
      end
   end

   for (genvar k = 0; k <= DS; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_ff[k].valid <= 1'b0;
         end else if (advance) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   // Output stage: encode quotient and remainder, pick the result.
   always_comb begin
      logic is_div;
      logic is_rem;
      logic [63:0] enc_q;
      logic [63:0] enc_r;
      is_div = (pipe_ff[DS].cmd == tia_pkg::CMD_DIV) || (pipe_ff[DS].cmd == tia_pkg::CMD_DIVREM);
      is_rem = (pipe_ff[DS].cmd == tia_pkg::CMD_DIVREM);
      enc_q = {{(64-MB-1){1'b0}}, pipe_ff[DS].sign_q && (pipe_ff[DS].dq != '0), pipe_ff[DS].dq};
      enc_r = {{(64-MB-1){1'b0}}, pipe_ff[DS].sign_r && (pipe_ff[DS].rem != '0), pipe_ff[DS].rem};
      out_data_in.fires = pipe_ff[DS].fires;
      out_data_in.divide_by_zero = pipe_ff[DS].dz;
      out_data_in.result_a = (is_div && pipe_ff[DS].fires) ? enc_q : pipe_ff[DS].val;
      out_data_in.result_b = (is_rem && pipe_ff[DS].fires) ? enc_r : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= pipe_ff[DS].valid;
         out_data_ff <= out_data_in;
      end
   end

   // Checks on the pipeline control and the result encoding.
   `TIA_ASSERT_IMPL(a_stall_only_when_blocked, clock, reset,
      req_stall, rsp_valid && rsp_stall)
   `TIA_ASSERT_IMPL(a_dz_never_fires, clock, reset,
      rsp_valid && rsp_data.divide_by_zero, !rsp_data.fires)
   `TIA_ASSERT_IMPL(a_remainder_needs_fire, clock, reset,
      rsp_valid && (rsp_data.result_b != 64'd0), rsp_data.fires && !rsp_data.divide_by_zero)
   `TIA_ASSERT_NEXT(a_stalled_word_held, clock, reset,
      rsp_valid && rsp_stall, rsp_valid)

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the tagged integer ALU: directed table, then random words.
module testbench;

   localparam int LATENCY = 18;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS = 900;
   localparam int DIRECTED_COUNT = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   tia_pkg::tia_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   tia_pkg::tia_rsp_type rsp_data;

   tagged_integer_alu uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   tia_pkg::tia_rsp_type expected_words[$];
   int mismatch_count = 0;
   int checked_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit timed_out = 1'b0;

   // Sign-magnitude decode of a datum to a two's complement value.
   function automatic logic [63:0] datum_value(input logic [63:0] d);
      logic [63:0] mag;
      mag = {19'd0, d[44:0]};
      return d[45] ? (64'd0 - mag) : mag;
   endfunction

   function automatic logic [63:0] pack_value(input logic [63:0] v);
      if (v[63]) return ((64'd0 - v) + 64'h0000200000000000) & 64'h00003fffffffffff;
      return v & 64'h00003fffffffffff;
   endfunction

   function automatic bit datum_is_numeric(input logic [63:0] d);
      return d[63:46] == 18'd0;
   endfunction

   // Predicts the result word of one request word.
   function automatic tia_pkg::tia_rsp_type alu_outcome(input tia_pkg::tia_req_type w);
      tia_pkg::tia_rsp_type r;
      logic [63:0] x, y, q, rm, ma, mb;
      bit both, lt, gt;
      r = '0;
      both = datum_is_numeric(w.operand_a) && datum_is_numeric(w.operand_b);
      x = datum_value(w.operand_a);
      y = datum_value(w.operand_b);
      lt = $signed(x) < $signed(y);
      gt = $signed(y) < $signed(x);
      case (w.command) inside
         tia_pkg::CMD_ADD: if (both) begin r.fires = 1; r.result_a = pack_value(x + y); end
         tia_pkg::CMD_SUB: if (both) begin r.fires = 1; r.result_a = pack_value(x - y); end
         tia_pkg::CMD_MUL: if (both) begin r.fires = 1; r.result_a = pack_value(x * y); end
         tia_pkg::CMD_DIV, tia_pkg::CMD_DIVREM: if (both) begin
            ma = {19'd0, w.operand_a[44:0]};
            mb = {19'd0, w.operand_b[44:0]};
            if (mb == 0) begin
               r.divide_by_zero = 1;
            end else begin
               q = ma / mb;
               rm = ma % mb;
               r.fires = 1;
               r.result_a = pack_value((w.operand_a[45] != w.operand_b[45]) ? -q : q);
               if (w.command == tia_pkg::CMD_DIVREM)
                  r.result_b = pack_value(w.operand_a[45] ? -rm : rm);
            end
         end
         tia_pkg::CMD_BSUBA: if (both) begin r.fires = 1; r.result_a = pack_value(y - x); end
         tia_pkg::CMD_INC: if (datum_is_numeric(w.operand_a)) begin
            r.fires = 1; r.result_a = pack_value(x + 64'd1);
         end
         tia_pkg::CMD_DEC: if (datum_is_numeric(w.operand_a)) begin
            r.fires = 1; r.result_a = pack_value(x - 64'd1);
         end
         tia_pkg::CMD_LT: r.fires = both && lt;
         tia_pkg::CMD_GT: r.fires = both && gt;
         tia_pkg::CMD_LE: r.fires = both && !gt;
         tia_pkg::CMD_GE: r.fires = both && !lt;
         tia_pkg::CMD_EQ: r.fires = w.operand_a == w.operand_b;
         tia_pkg::CMD_NE: r.fires = w.operand_a != w.operand_b;
         tia_pkg::CMD_ISNUM: r.fires = datum_is_numeric(w.operand_a);
         tia_pkg::CMD_NOTNUM: r.fires = !datum_is_numeric(w.operand_a);
         tia_pkg::CMD_NOP: r.fires = 1;
         tia_pkg::CMD_PASS: begin r.fires = 1; r.result_a = w.operand_a; end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Directed table; a row with has_answer set carries its result typed in.
   typedef struct {
      tia_pkg::tia_req_type word;
      bit has_answer;
      tia_pkg::tia_rsp_type answer;
   } directed_row_type;
   directed_row_type directed[DIRECTED_COUNT];

   localparam logic [63:0] MAXPOS = 64'h00001fffffffffff;
   localparam logic [63:0] MAXNEG = 64'h00003fffffffffff;
   localparam logic [63:0] NEGZERO = 64'h0000200000000000;
   localparam logic [63:0] TAGGED = 64'hffffc00000000000;

   function automatic directed_row_type row(input logic [4:0] c, input logic [63:0] a,
                                           input logic [63:0] b, input bit k,
                                           input bit f, input logic [63:0] ra,
                                           input logic [63:0] rb, input bit dz);
      directed_row_type d;
      d.word = '{command: c, operand_a: a, operand_b: b};
      d.has_answer = k;
      d.answer = '{fires: f, result_a: ra, result_b: rb, divide_by_zero: dz};
      return d;
   endfunction

   initial begin
      directed[0]  = row(tia_pkg::CMD_ADD, 64'd3, 64'd4, 1, 1, 64'd7, 0, 0);
      directed[1]  = row(tia_pkg::CMD_ADD, MAXPOS, MAXPOS, 0, 0, 0, 0, 0);
      directed[2]  = row(tia_pkg::CMD_SUB, 64'd2, 64'd5, 0, 0, 0, 0, 0);
      directed[3]  = row(tia_pkg::CMD_MUL, MAXNEG, MAXPOS, 0, 0, 0, 0, 0);
      directed[4]  = row(tia_pkg::CMD_DIV, 64'd7, 64'd0, 1, 0, 0, 0, 1);
      directed[5]  = row(tia_pkg::CMD_DIVREM, 64'd7, NEGZERO, 1, 0, 0, 0, 1);
      directed[6]  = row(tia_pkg::CMD_DIVREM, NEGZERO | 64'd7, 64'd2, 0, 0, 0, 0, 0);
      directed[7]  = row(tia_pkg::CMD_DIV, MAXNEG, 64'd3, 0, 0, 0, 0, 0);
      directed[8]  = row(tia_pkg::CMD_BSUBA, 64'd9, MAXNEG, 0, 0, 0, 0, 0);
      directed[9]  = row(tia_pkg::CMD_INC, MAXPOS, 0, 0, 0, 0, 0, 0);
      directed[10] = row(tia_pkg::CMD_DEC, NEGZERO, 0, 0, 0, 0, 0, 0);
      directed[11] = row(tia_pkg::CMD_LT, NEGZERO, 64'd0, 1, 0, 0, 0, 0);
      directed[12] = row(tia_pkg::CMD_GT, 64'd1, MAXNEG, 1, 1, 0, 0, 0);
      directed[13] = row(tia_pkg::CMD_LE, NEGZERO, 64'd0, 1, 1, 0, 0, 0);
      directed[14] = row(tia_pkg::CMD_GE, MAXNEG, MAXPOS, 1, 0, 0, 0, 0);
      directed[15] = row(tia_pkg::CMD_EQ, NEGZERO, 64'd0, 1, 0, 0, 0, 0);
      directed[16] = row(tia_pkg::CMD_NE, '1, '1, 1, 0, 0, 0, 0);
      directed[17] = row(tia_pkg::CMD_ISNUM, TAGGED, 0, 1, 0, 0, 0, 0);
      directed[18] = row(tia_pkg::CMD_NOTNUM, 64'h0000400000000000, 0, 1, 1, 0, 0, 0);
      directed[19] = row(tia_pkg::CMD_NOP, '1, '1, 1, 1, 0, 0, 0);
      directed[20] = row(tia_pkg::CMD_PASS, '1, 0, 1, 1, '1, 0, 0);
      directed[21] = row(tia_pkg::CMD_ADD, TAGGED, 64'd1, 1, 0, 0, 0, 0);
      directed[22] = row(tia_pkg::CMD_LT, 64'd1, 64'h8000000000000000, 1, 0, 0, 0, 0);
      directed[23] = row(5'd31, '1, '1, 1, 0, 0, 0, 0);
   end

   // Random datum: mostly numbers, some tagged words, some extremes.
   function automatic logic [63:0] random_datum();
      logic [63:0] d;
      int pick;
      pick = $urandom_range(0, 9);
      d = {$urandom(), $urandom()};
      case (pick)
         0: d = '1;
         1: d = $urandom_range(0, 1) ? MAXPOS : MAXNEG;
         2: d = $urandom_range(0, 1) ? 64'd0 : NEGZERO;
         3: ;
         4: d = d & 64'h000020000000000f;
         default: d = d & tia_pkg::LOW46_MASK;
      endcase
      return d;
   endfunction

   // Sends one word and files its expected result once it is accepted.
   task automatic send_word(input tia_pkg::tia_req_type w, input bit has_answer,
                            input tia_pkg::tia_rsp_type answer);
      tia_pkg::tia_rsp_type want;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      want = has_answer ? answer : alu_outcome(w);
      expected_words.insert(expected_words.size(), want);
   endtask

   // Receiver stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Result checking.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_data.result_a, 64'd0);
         end else begin
            tia_pkg::tia_rsp_type want;
            want = expected_words.pop_front();
            checked_count++;
            if (rsp_data.fires !== want.fires)
               report_mismatch("fires", 64'(rsp_data.fires), 64'(want.fires));
            if (rsp_data.result_a !== want.result_a)
               report_mismatch("result_a", rsp_data.result_a, want.result_a);
            if (rsp_data.result_b !== want.result_b)
               report_mismatch("result_b", rsp_data.result_b, want.result_b);
            if (rsp_data.divide_by_zero !== want.divide_by_zero)
               report_mismatch("divide_by_zero", 64'(rsp_data.divide_by_zero),
                               64'(want.divide_by_zero));
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Watchdog expired with %0d words outstanding", expected_words.size());
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      tia_pkg::tia_req_type w;
      tia_pkg::tia_rsp_type none;
      int phase;
      none = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 11;
      recv_idle_pct = 83;
      foreach (directed[i]) send_word(directed[i].word, directed[i].has_answer,
                                      directed[i].answer);
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 83 : 0;
         recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 11 : 0;
         repeat (RANDOM_WORDS / 3) begin
            w.command = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                                      : 5'($urandom_range(0, 17));
            w.operand_a = random_datum();
            w.operand_b = ($urandom_range(0, 9) == 0) ? w.operand_a : random_datum();
            send_word(w, 1'b0, none);
         end
      end
      req_valid <= 1'b0;

      while (expected_words.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      $display("Checked %0d result words over all commands, operand extremes and",
               checked_count);
      $display("tagged operands, under three sender and receiver idle patterns.");
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
